### src/bitmap_frame_allocator_core_macros.svh
// assertion helpers for the frame allocator, sampled on clk, muted during rst
`ifndef BITMAP_FRAME_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_CORE_MACROS_SVH

// condition holds in the same cycle
`define BFA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition holds in the following cycle
`define BFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/bfa_pkg.sv
`default_nettype none
package bfa_pkg;

  localparam int FUNC_W   = 2;
  localparam int ADDR_W   = 32;
  localparam int STATUS_W = 2;
  localparam int GRANT_W  = 27;
  localparam int COUNT_W  = 16;

  localparam logic [FUNC_W-1:0] FN_ALLOC   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_FREE    = 2'd1;
  localparam logic [FUNC_W-1:0] FN_RESERVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SAME  = 2'd3;

  localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = 16'd32768;

  typedef enum logic [1:0] {
    S_CLR,
    S_IDLE,
    S_SUM,
    S_MOD
  } state_t;

  // index of the lowest clear bit of a 32-bit word
  function automatic logic [4:0] lowest_zero(input logic [31:0] w);
    logic [4:0] idx;
    idx = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (!w[i]) idx = 5'(i);
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

### src/bfa_if.sv
`default_nettype none
interface bfa_req_if;
  logic                        valid;
  logic                        ready;
  logic [bfa_pkg::FUNC_W-1:0]  func;
  logic [bfa_pkg::ADDR_W-1:0]  frame_address;
  modport source (output valid, func, frame_address, input ready);
  modport sink (input valid, func, frame_address, output ready);
endinterface

interface bfa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bfa_pkg::STATUS_W-1:0]  status;
  logic [bfa_pkg::GRANT_W-1:0]   granted_address;
  logic [bfa_pkg::COUNT_W-1:0]   free_count;
  modport source (output valid, status, granted_address, free_count, input ready);
  modport sink (input valid, status, granted_address, free_count, output ready);
endinterface

interface bfa_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bfa_pkg::COUNT_W-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

### src/bitmap_frame_allocator_core.sv
// channel | dir | payload                                  | transaction
// cfg     | in  | data = frame_count                        | valid & ready
// req     | in  | func, frame_address                       | valid & ready
// rsp     | out | status, granted_address, free_count       | valid & ready
//
// sequence: allocate reads the summary word, then the bitmap word, then writes back
//   and loads its result; free, reserve and the unused code read both words together,
//   then write back and load theirs; one item at a time
// reset: a clearing pass writes every bitmap word, 2**(SIDX_W+5) of them
//   (1024 at the default size), while req is held not ready; cfg is always taken
// stalls: the write back waits only while the rsp register holds an untaken result
`default_nettype none
`include "bitmap_frame_allocator_core_macros.svh"
module bitmap_frame_allocator_core #(
  parameter int MAX_FRAMES = 32768,
  parameter int PAGE_SHIFT = 12
) (
  input  wire      clk,
  input  wire      rst,
  bfa_cfg_if.sink  cfg,
  bfa_req_if.sink  req,
  bfa_rsp_if.source rsp
);

  // bitmap words hold 32 frames, summary words hold one full flag per bitmap word
  localparam int SIDX_W  = (MAX_FRAMES > 1024) ? $clog2((MAX_FRAMES + 1023) / 1024) : 1;
  localparam int SDEPTH  = 1 << SIDX_W;
  localparam int WIDX_W  = SIDX_W + 5;
  localparam int BDEPTH  = 1 << WIDX_W;
  localparam int FRAME_W = WIDX_W + 5;

  bfa_pkg::state_t state, state_next;

  // configuration
  logic [bfa_pkg::COUNT_W-1:0] frame_count;
  logic [bfa_pkg::COUNT_W-1:0] n_active;

  // memories with registered read data
  logic [31:0] bm_mem  [BDEPTH];
  logic [31:0] sum_mem [SDEPTH];
  logic [31:0] bm_rdata, sum_rdata;
  logic        bm_re, bm_we, sum_re, sum_we;
  logic [WIDX_W-1:0] bm_raddr, bm_waddr;
  logic [SIDX_W-1:0] sum_raddr, sum_waddr;
  logic [31:0] bm_wdata, sum_wdata;

  // one flag per summary word: every bitmap word under it is full
  logic [SDEPTH-1:0] top_full;
  logic [SIDX_W-1:0] top_sel;

  logic [WIDX_W-1:0] clr_idx;
  logic [bfa_pkg::COUNT_W-1:0] used_total, used_next;

  // item held while it is worked on
  logic [bfa_pkg::FUNC_W-1:0] op_func;
  logic [SIDX_W-1:0] cur_sidx;
  logic [4:0]        cur_wlow;
  logic [4:0]        cur_bit;
  logic              op_range;
  logic              op_no_free;

  localparam int ADDR_W_LOCAL = bfa_pkg::ADDR_W;
  logic [ADDR_W_LOCAL-1:0] req_frame;

  // result register
  logic                          rsp_valid;
  logic [bfa_pkg::STATUS_W-1:0]  rsp_status;
  logic [bfa_pkg::GRANT_W-1:0]   rsp_granted;
  logic [bfa_pkg::COUNT_W-1:0]   rsp_free;

  // read-modify-write signals
  logic [4:0]         alloc_wlow;
  logic [4:0]         alloc_bit;
  logic [4:0]         op_bit;
  logic [FRAME_W-1:0] op_frame;
  logic               want_set;
  logic [31:0]        new_word;
  logic [31:0]        new_sum;
  logic               do_write;
  logic               commit;
  logic [bfa_pkg::STATUS_W-1:0] status_next;
  logic [bfa_pkg::GRANT_W-1:0]  granted_next;
  logic [bfa_pkg::COUNT_W-1:0]  free_next;
  logic [63:0]        granted_wide;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= bfa_pkg::FRAME_COUNT_RESET;
    end else if (cfg.valid) begin
      frame_count <= cfg.data;
    end
  end

  // frame_count above the build limit acts as the limit
  assign n_active = (32'(frame_count) > 32'(MAX_FRAMES)) ? 16'(MAX_FRAMES) : frame_count;

  assign req_frame = req.frame_address >> PAGE_SHIFT;

  // lowest summary word that still has a non-full bitmap word
  always_comb begin
    top_sel = '0;
    for (int i = SDEPTH - 1; i >= 0; i--) begin
      if (!top_full[i]) top_sel = SIDX_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
    if (bm_re) bm_rdata <= bm_mem[bm_raddr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    if (sum_re) sum_rdata <= sum_mem[sum_raddr];
  end

  // modify step
  assign alloc_wlow = bfa_pkg::lowest_zero(sum_rdata);
  assign alloc_bit  = bfa_pkg::lowest_zero(bm_rdata);
  assign op_bit     = (op_func == bfa_pkg::FN_ALLOC) ? alloc_bit : cur_bit;
  assign op_frame   = {cur_sidx, cur_wlow, op_bit};
  assign want_set   = (op_func != bfa_pkg::FN_FREE);

  always_comb begin
    new_word = bm_rdata;
    new_word[op_bit] = want_set;
    new_sum = sum_rdata;
    new_sum[cur_wlow] = &new_word;
  end

  assign granted_wide = 64'(op_frame) << PAGE_SHIFT;

  always_comb begin
    status_next  = bfa_pkg::ST_OK;
    granted_next = '0;
    do_write     = 1'b0;
    used_next    = used_total;
    case (op_func) inside
      bfa_pkg::FN_ALLOC: begin
        // lowest free frame overall; at or beyond the active count means none below it
        if (op_no_free || (32'(op_frame) >= 32'(n_active))) begin
          status_next = bfa_pkg::ST_OOM;
        end else begin
          do_write     = 1'b1;
          used_next    = used_total + 16'd1;
          granted_next = granted_wide[bfa_pkg::GRANT_W-1:0];
        end
      end
      bfa_pkg::FN_FREE, bfa_pkg::FN_RESERVE: begin
        if (op_range) begin
          status_next = bfa_pkg::ST_RANGE;
        end else if (bm_rdata[cur_bit] == want_set) begin
          status_next = bfa_pkg::ST_SAME;
        end else begin
          do_write = 1'b1;
          if (want_set) begin
            used_next = used_total + 16'd1;
          end else if (used_total != '0) begin
            used_next = used_total - 16'd1;
          end
        end
      end
      default: begin
        // unused code: report the count only
      end
    endcase
  end

  assign free_next = (n_active > used_next) ? n_active - used_next : '0;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= bfa_pkg::S_CLR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    bm_re      = 1'b0;
    bm_raddr   = req_frame[FRAME_W-1:5];
    sum_re     = 1'b0;
    sum_raddr  = req_frame[FRAME_W-1:10];
    bm_we      = 1'b0;
    bm_waddr   = {cur_sidx, cur_wlow};
    bm_wdata   = new_word;
    sum_we     = 1'b0;
    sum_waddr  = cur_sidx;
    sum_wdata  = new_sum;
    commit     = 1'b0;
    unique case (state)
      bfa_pkg::S_CLR: begin
        bm_we     = 1'b1;
        bm_waddr  = clr_idx;
        bm_wdata  = '0;
        sum_we    = 1'b1;
        sum_waddr = clr_idx[SIDX_W-1:0];
        sum_wdata = '0;
        if (clr_idx == WIDX_W'(BDEPTH - 1)) state_next = bfa_pkg::S_IDLE;
      end
      bfa_pkg::S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          bm_re  = 1'b1;
          sum_re = 1'b1;
          if (req.func == bfa_pkg::FN_ALLOC) begin
            sum_raddr  = top_sel;
            state_next = bfa_pkg::S_SUM;
          end else begin
            state_next = bfa_pkg::S_MOD;
          end
        end
      end
      bfa_pkg::S_SUM: begin
        // summary word in hand, fetch the first non-full bitmap word
        bm_re      = 1'b1;
        bm_raddr   = {cur_sidx, alloc_wlow};
        state_next = bfa_pkg::S_MOD;
      end
      bfa_pkg::S_MOD: begin
        if (!rsp_valid || rsp.ready) begin
          commit     = 1'b1;
          bm_we      = do_write;
          sum_we     = do_write;
          state_next = bfa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bfa_pkg::S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (state == bfa_pkg::S_CLR) begin
      clr_idx <= clr_idx + WIDX_W'(1);
    end
  end

  // capture the item, and the chosen bitmap word for allocate
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_func    <= req.func;
      op_range   <= ({16'd0, req_frame[31:16]} != 32'd0) ||
                    (req_frame[15:0] >= n_active);
      op_no_free <= &top_full;
      cur_bit    <= req_frame[4:0];
      if (req.func == bfa_pkg::FN_ALLOC) begin
        cur_sidx <= top_sel;
        cur_wlow <= '0;
      end else begin
        cur_sidx <= req_frame[FRAME_W-1:10];
        cur_wlow <= req_frame[9:5];
      end
    end else if (state == bfa_pkg::S_SUM) begin
      cur_wlow <= alloc_wlow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_total <= '0;
      top_full   <= '0;
    end else if (commit) begin
      used_total <= used_next;
      if (do_write) top_full[cur_sidx] <= &new_sum;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp_status  <= status_next;
      rsp_granted <= granted_next;
      rsp_free    <= free_next;
    end
  end

  assign rsp.valid           = rsp_valid;
  assign rsp.status          = rsp_status;
  assign rsp.granted_address = rsp_granted;
  assign rsp.free_count      = rsp_free;

  // checks
  `BFA_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready,
                   "request taken while an item is in progress")
  `BFA_ASSERT_SAME(a_grant_only_ok, rsp.valid && (rsp.granted_address != '0),
                   rsp.status == bfa_pkg::ST_OK, "address granted on a failed request")
  `BFA_ASSERT_NEXT(a_commit_ends_item, commit,
                   rsp.valid && (state == bfa_pkg::S_IDLE), "write back did not close the item")

endmodule
`default_nettype wire
